[rtl/i2c_register_map_target_top_defines.svh]
// ----------------------------------------------------------------------------
// I2C register map target assertion macros
// Shared assertion wrappers, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_MAP_TARGET_TOP_DEFINES_SVH
`define I2C_REGISTER_MAP_TARGET_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define I2CRM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define I2CRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define I2CRM_ASSERT_IMPL(lbl, ante, cons)
`define I2CRM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/i2crm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C register map target package
// Action codes, address windows, result codes and the pipeline record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2crm_pkg;

  localparam logic [2:0] ACT_WRITE_START = 3'd0;
  localparam logic [2:0] ACT_READ_START  = 3'd1;
  localparam logic [2:0] ACT_RX_BYTE     = 3'd2;
  localparam logic [2:0] ACT_TX_REQUEST  = 3'd3;
  localparam logic [2:0] ACT_STOP        = 3'd4;
  localparam logic [2:0] ACT_LOCAL_WRITE = 3'd5;
  localparam logic [2:0] ACT_LOCAL_READ  = 3'd6;

  localparam logic [7:0] WR_LOW_END    = 8'h4F;
  localparam logic [7:0] WR_SINGLE     = 8'h70;
  localparam logic [7:0] WR_HIGH_START = 8'h90;

  localparam logic [1:0] CHK_NONE     = 2'd0;
  localparam logic [1:0] CHK_MATCH    = 2'd1;
  localparam logic [1:0] CHK_MISMATCH = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE        = 3'd0,
    OP_SUM_CLEAR   = 3'd1,
    OP_SUM_ADD     = 3'd2,
    OP_COMPARE     = 3'd3,
    OP_TX_DATA     = 3'd4,
    OP_TX_CHECKSUM = 3'd5,
    OP_LOCAL_READ  = 3'd6
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic       stored;
    logic       rd_hit;
  } pipe_t;

  function automatic logic addr_writable(input logic [7:0] a);
    return (a <= WR_LOW_END) || (a == WR_SINGLE) || (a >= WR_HIGH_START);
  endfunction

endpackage

[rtl/i2crm_item_if.sv]
// ----------------------------------------------------------------------------
// I2C register map target input channel
// Valid/ready channel carrying one bus or local action per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2crm_item_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] bus_data;
  logic [7:0] local_addr;

  modport source (output valid, action, bus_data, local_addr, input ready);
  modport sink (input valid, action, bus_data, local_addr, output ready);
endinterface

[rtl/i2crm_result_if.sv]
// ----------------------------------------------------------------------------
// I2C register map target result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface i2crm_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       tx_is_checksum;
  logic       stored;
  logic [1:0] check_result;

  modport source (output valid, out_byte, tx_is_checksum, stored, check_result,
                  input ready);
  modport sink (input valid, out_byte, tx_is_checksum, stored, check_result,
                output ready);
endinterface

[rtl/i2crm_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2crm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 144,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/i2crm_ctrl.sv]
// ----------------------------------------------------------------------------
// I2C register map target frame control
// Decodes actions, tracks pointer and framing, drives the map ports and
// per-entry written bits, and hands each transaction to the response stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2crm_ctrl import i2crm_pkg::*; #(
  parameter int MAP_SIZE = 144,
  parameter int ADDR_W   = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1
) (
  input  logic              clk,
  input  logic              rst,
  i2crm_item_if.sink        item,
  output pipe_t             pipe,
  output logic              pipe_valid,
  input  logic              pipe_ready,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [7:0]        ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr
);

  logic [7:0]          reg_pointer, reg_pointer_next;
  logic                expect_address, expect_address_next;
  logic [7:0]          frame_length, frame_length_next;
  logic [7:0]          byte_count, byte_count_next;
  logic [MAP_SIZE-1:0] written;

  logic       accept;
  logic       we, re, rd_in_range, stored;
  logic [7:0] waddr, raddr;
  logic [8:0] ptr_plus;
  logic [7:0] ptr_inc;
  logic       ptr_in_range, laddr_in_range, rd_hit;
  op_t        op;

  assign item.ready = !pipe_valid || pipe_ready;
  assign accept     = item.valid && item.ready;

  assign ptr_plus       = {1'b0, reg_pointer} + 9'd1;
  assign ptr_inc        = (ptr_plus >= 9'(MAP_SIZE)) ? 8'd0 : ptr_plus[7:0];
  assign ptr_in_range   = {1'b0, reg_pointer} < 9'(MAP_SIZE);
  assign laddr_in_range = {1'b0, item.local_addr} < 9'(MAP_SIZE);

  always_comb begin
    reg_pointer_next    = reg_pointer;
    expect_address_next = expect_address;
    frame_length_next   = frame_length;
    byte_count_next     = byte_count;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = reg_pointer;
    raddr       = reg_pointer;
    rd_in_range = 1'b0;
    stored      = 1'b0;
    op          = OP_NONE;
    case (item.action)
      ACT_WRITE_START: begin
        expect_address_next = 1'b1;
      end
      ACT_READ_START: begin
        expect_address_next = 1'b0;
        byte_count_next     = 8'd0;
        op                  = OP_SUM_CLEAR;
      end
      ACT_RX_BYTE: begin
        if (expect_address) begin
          reg_pointer_next    = item.bus_data;
          expect_address_next = 1'b0;
          byte_count_next     = 8'd0;
          op                  = OP_SUM_CLEAR;
        end else if (byte_count == 8'd0) begin
          frame_length_next = item.bus_data;
          byte_count_next   = 8'd1;
        end else if (byte_count <= frame_length) begin
          if (ptr_in_range && addr_writable(reg_pointer)) begin
            we     = 1'b1;
            stored = 1'b1;
          end
          op               = OP_SUM_ADD;
          reg_pointer_next = ptr_inc;
          byte_count_next  = byte_count + 8'd1;
        end else begin
          op = OP_COMPARE;
        end
      end
      ACT_TX_REQUEST: begin
        if (byte_count < frame_length) begin
          re               = 1'b1;
          rd_in_range      = ptr_in_range;
          op               = OP_TX_DATA;
          reg_pointer_next = ptr_inc;
          byte_count_next  = byte_count + 8'd1;
        end else begin
          op              = OP_TX_CHECKSUM;
          byte_count_next = 8'd0;
        end
      end
      ACT_STOP: begin
        reg_pointer_next    = 8'd0;
        expect_address_next = 1'b0;
        frame_length_next   = 8'd0;
        byte_count_next     = 8'd0;
        op                  = OP_SUM_CLEAR;
      end
      ACT_LOCAL_WRITE: begin
        we    = laddr_in_range;
        waddr = item.local_addr;
      end
      ACT_LOCAL_READ: begin
        re          = 1'b1;
        raddr       = item.local_addr;
        rd_in_range = laddr_in_range;
        op          = OP_LOCAL_READ;
      end
      default: begin
        op = OP_NONE;
      end
    endcase
  end

  assign rd_hit    = rd_in_range && written[raddr[ADDR_W-1:0]];
  assign ram_we    = accept && we;
  assign ram_waddr = waddr[ADDR_W-1:0];
  assign ram_wdata = item.bus_data;
  assign ram_re    = accept && re;
  assign ram_raddr = raddr[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_pointer    <= 8'd0;
      expect_address <= 1'b0;
      frame_length   <= 8'd0;
      byte_count     <= 8'd0;
      written        <= '0;
      pipe_valid     <= 1'b0;
    end else begin
      if (accept) begin
        reg_pointer    <= reg_pointer_next;
        expect_address <= expect_address_next;
        frame_length   <= frame_length_next;
        byte_count     <= byte_count_next;
        pipe_valid     <= 1'b1;
        if (we) begin
          written[waddr[ADDR_W-1:0]] <= 1'b1;
        end
      end else if (pipe_ready) begin
        pipe_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pipe.op     <= op;
      pipe.data   <= item.bus_data;
      pipe.stored <= stored;
      pipe.rd_hit <= rd_hit;
    end
  end

endmodule

[rtl/i2crm_resp.sv]
// ----------------------------------------------------------------------------
// I2C register map target response stage
// Keeps the running sum, forms checksum bytes and comparisons, and holds
// the result register toward the sink.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2crm_resp import i2crm_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  pipe_t          pipe,
  input  logic           pipe_valid,
  output logic           pipe_ready,
  input  logic [7:0]     ram_rdata,
  i2crm_result_if.source result
);

  logic [7:0] running_sum, running_sum_next;
  logic [7:0] rbyte, ob;
  logic       is_ck, st;
  logic [1:0] chk;
  logic       advance;

  assign pipe_ready = !result.valid || result.ready;
  assign advance    = pipe_valid && pipe_ready;
  assign rbyte      = pipe.rd_hit ? ram_rdata : 8'd0;

  always_comb begin
    running_sum_next = running_sum;
    ob    = 8'd0;
    is_ck = 1'b0;
    st    = 1'b0;
    chk   = CHK_NONE;
    case (pipe.op)
      OP_SUM_CLEAR: begin
        running_sum_next = 8'd0;
      end
      OP_SUM_ADD: begin
        running_sum_next = running_sum + pipe.data;
        st               = pipe.stored;
      end
      OP_COMPARE: begin
        chk = (~running_sum == pipe.data) ? CHK_MATCH : CHK_MISMATCH;
      end
      OP_TX_DATA: begin
        ob               = rbyte;
        running_sum_next = running_sum + rbyte;
      end
      OP_TX_CHECKSUM: begin
        ob    = ~running_sum;
        is_ck = 1'b1;
      end
      OP_LOCAL_READ: begin
        ob = rbyte;
      end
      default: begin
        ob = 8'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= 8'd0;
      result.valid <= 1'b0;
    end else begin
      if (advance) begin
        running_sum  <= running_sum_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.out_byte       <= ob;
      result.tx_is_checksum <= is_ck;
      result.stored         <= st;
      result.check_result   <= chk;
    end
  end

endmodule

[rtl/i2c_register_map_target_top.sv]
// ----------------------------------------------------------------------------
// I2C register map target top level
// Path: an accepted transaction is registered in the pipe record and the map
// read data, then in the result register once the result slot is free.
// Throughput: one transaction per cycle while results are taken; the
// map RAM has one write and one read port; each action uses it at most once.
// Reset: synchronous; the map reads as zero at once through per-entry
// written bits, with no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_register_map_target_top_defines.svh"

module i2c_register_map_target_top import i2crm_pkg::*; #(
  parameter int MAP_SIZE = 144
) (
  input  logic           clk,
  input  logic           rst,
  i2crm_item_if.sink     item,
  i2crm_result_if.source result
);

  localparam int AW = (MAP_SIZE > 1) ? $clog2(MAP_SIZE) : 1;

  pipe_t          pipe;
  logic           pipe_valid;
  logic           pipe_ready;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  i2crm_ctrl #(
    .MAP_SIZE (MAP_SIZE),
    .ADDR_W   (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .pipe       (pipe),
    .pipe_valid (pipe_valid),
    .pipe_ready (pipe_ready),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr)
  );

  i2crm_ram #(
    .WIDTH  (8),
    .DEPTH  (MAP_SIZE),
    .ADDR_W (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  i2crm_resp u_resp (
    .clk        (clk),
    .rst        (rst),
    .pipe       (pipe),
    .pipe_valid (pipe_valid),
    .pipe_ready (pipe_ready),
    .ram_rdata  (ram_rdata),
    .result     (result)
  );

  `I2CRM_ASSERT_IMPL(a_stall_blocks_input, pipe_valid && !pipe_ready, !item.ready)
  `I2CRM_ASSERT_NEXT(a_accept_fills_pipe, item.valid && item.ready, pipe_valid)
  `I2CRM_ASSERT_IMPL(a_st_ck, result.valid && result.stored, !result.tx_is_checksum)
  `I2CRM_ASSERT_IMPL(a_st_chk, result.valid && result.stored, result.check_result == CHK_NONE)

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// I2C register map target testbench
// Drives bus frames, local map accesses and stray actions into the target,
// and predicts every result from a model of the map and the frame state that
// the testbench keeps itself. Results are compared field by field, in order,
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import i2crm_pkg::*;

  localparam int MAP_DEPTH = 144;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       tx_is_checksum;
    logic       stored;
    logic [1:0] check_result;
  } target_result_t;

  logic clk = 1'b0;
  logic rst;

  i2crm_item_if   item_ch();
  i2crm_result_if result_ch();

  i2c_register_map_target_top #(
    .MAP_SIZE(MAP_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the target state.
  logic [7:0] shadow_map [MAP_DEPTH];
  logic [7:0] shadow_ptr;
  logic       awaiting_addr;
  logic [7:0] frame_len;
  logic [7:0] frame_count;
  logic [7:0] frame_sum;

  target_result_t expected_results[$];
  target_result_t want;

  bit idle_on;
  int sink_hold;
  int items_sent;
  int error_count;
  int bytes_stored;
  int checksum_matches;
  int checksum_mismatches;
  int checksums_sent;
  int frames_written;
  int frames_read;

  function automatic void advance_shadow_ptr();
    int nxt;
    nxt = int'(shadow_ptr) + 1;
    shadow_ptr = (nxt >= MAP_DEPTH) ? 8'd0 : nxt[7:0];
  endfunction

  function automatic void clear_shadow_frame();
    awaiting_addr = 1'b0;
    shadow_ptr = 8'd0;
    frame_len = 8'd0;
    frame_count = 8'd0;
    frame_sum = 8'd0;
  endfunction

  function automatic target_result_t predict_target(input logic [2:0] act,
                                                    input logic [7:0] data,
                                                    input logic [7:0] laddr);
    target_result_t r;
    logic [7:0] rd;
    r = '0;
    rd = 8'd0;
    case (act)
      ACT_WRITE_START: begin
        awaiting_addr = 1'b1;
      end
      ACT_READ_START: begin
        awaiting_addr = 1'b0;
        frame_count = 8'd0;
        frame_sum = 8'd0;
      end
      ACT_RX_BYTE: begin
        if (awaiting_addr) begin
          shadow_ptr = data;
          awaiting_addr = 1'b0;
          frame_count = 8'd0;
          frame_sum = 8'd0;
        end else if (frame_count == 8'd0) begin
          frame_len = data;
          frame_count = 8'd1;
        end else if (frame_count <= frame_len) begin
          if (int'(shadow_ptr) < MAP_DEPTH && (shadow_ptr <= WR_LOW_END ||
              shadow_ptr == WR_SINGLE || shadow_ptr >= WR_HIGH_START)) begin
            shadow_map[shadow_ptr] = data;
            r.stored = 1'b1;
            bytes_stored++;
          end
          frame_sum = frame_sum + data;
          advance_shadow_ptr();
          frame_count = frame_count + 8'd1;
        end else begin
          rd = ~frame_sum;
          r.check_result = (rd == data) ? CHK_MATCH : CHK_MISMATCH;
          if (rd == data) checksum_matches++;
          else checksum_mismatches++;
        end
      end
      ACT_TX_REQUEST: begin
        if (frame_count < frame_len) begin
          if (int'(shadow_ptr) < MAP_DEPTH) rd = shadow_map[shadow_ptr];
          r.out_byte = rd;
          frame_sum = frame_sum + rd;
          advance_shadow_ptr();
          frame_count = frame_count + 8'd1;
        end else begin
          r.out_byte = ~frame_sum;
          r.tx_is_checksum = 1'b1;
          frame_count = 8'd0;
          checksums_sent++;
        end
      end
      ACT_STOP: begin
        clear_shadow_frame();
      end
      ACT_LOCAL_WRITE: begin
        if (int'(laddr) < MAP_DEPTH) shadow_map[laddr] = data;
      end
      ACT_LOCAL_READ: begin
        if (int'(laddr) < MAP_DEPTH) r.out_byte = shadow_map[laddr];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic send_action(input logic [2:0] act, input logic [7:0] data,
                             input logic [7:0] laddr);
    int gap;
    gap = idle_on ? int'($urandom_range(0, 16)) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.action <= act;
    item_ch.bus_data <= data;
    item_ch.local_addr <= laddr;
    do @(posedge clk); while (!item_ch.ready);
    expected_results.push_back(predict_target(act, data, laddr));
    items_sent++;
  endtask

  task automatic rx_byte(input logic [7:0] data);
    send_action(ACT_RX_BYTE, data, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_frame(input logic [7:0] start_addr, input logic [7:0] len,
                             input bit bad_sum, input int extras, input bit stop);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd0;
    send_action(ACT_WRITE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    rx_byte(start_addr);
    rx_byte(len);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom_range(0, 255));
      sum = sum + b;
      rx_byte(b);
    end
    rx_byte(bad_sum ? (~sum ^ 8'($urandom_range(1, 255))) : ~sum);
    for (int i = 0; i < extras; i++) rx_byte(8'($urandom_range(0, 255)));
    if (stop) send_action(ACT_STOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    frames_written++;
  endtask

  task automatic read_frame(input logic [7:0] start_addr, input logic [7:0] len,
                            input int requests, input bit stop);
    send_action(ACT_WRITE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    rx_byte(start_addr);
    rx_byte(len);
    send_action(ACT_READ_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    for (int i = 0; i < requests; i++) begin
      send_action(ACT_TX_REQUEST, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end
    if (stop) send_action(ACT_STOP, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    frames_read++;
  endtask

  task automatic wait_for_drain();
    item_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_local_ports();
    idle_on = 1'b0;
    send_action(ACT_LOCAL_WRITE, 8'hFF, 8'h00);
    send_action(ACT_LOCAL_WRITE, 8'hA5, 8'hFF);
    send_action(ACT_LOCAL_READ, 8'h00, 8'h00);
    send_action(ACT_LOCAL_READ, 8'hFF, 8'hFF);
    send_action(ACT_LOCAL_READ, 8'h00, 8'h8F);
  endtask

  task automatic test_write_frame();
    idle_on = 1'b1;
    send_action(ACT_WRITE_START, 8'h00, 8'h00);
    rx_byte(8'h4F);
    rx_byte(8'd2);
    rx_byte(8'hFF);
    rx_byte(8'h00);
    rx_byte(8'h00);
    rx_byte(8'h11);
    send_action(ACT_STOP, 8'h00, 8'h00);
  endtask

  task automatic test_read_frame();
    idle_on = 1'b0;
    send_action(ACT_WRITE_START, 8'h00, 8'h00);
    rx_byte(8'h4F);
    rx_byte(8'd1);
    send_action(ACT_READ_START, 8'h00, 8'h00);
    send_action(ACT_TX_REQUEST, 8'h00, 8'h00);
    send_action(ACT_TX_REQUEST, 8'h00, 8'h00);
    send_action(ACT_TX_REQUEST, 8'h00, 8'h00);
    send_action(ACT_STOP, 8'h00, 8'h00);
  endtask

  task automatic test_stray_actions();
    idle_on = 1'b1;
    send_action(ACT_UNUSED, 8'hFF, 8'hFF);
    send_action(ACT_WRITE_START, 8'h00, 8'h00);
    rx_byte(8'hC8);
    rx_byte(8'd0);
    rx_byte(8'hFF);
  endtask

  task automatic test_random_traffic();
    int goal;
    int pick;
    logic [7:0] start_addr;
    logic [7:0] len;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      if ($urandom_range(0, 3) == 0) idle_on = ~idle_on;
      pick = int'($urandom_range(0, 99));
      case ($urandom_range(0, 9))
        0, 1: start_addr = 8'($urandom_range(0, 255));
        2, 3: start_addr = 8'($urandom_range(0, 4) == 0 ? 8'h8F :
                         ($urandom_range(0, 1) ? 8'h4E : 8'h6F));
        default: start_addr = 8'($urandom_range(0, 8'h8F));
      endcase
      if ($urandom_range(0, 59) == 0) len = 8'd255;
      else if ($urandom_range(0, 6) == 0) len = 8'($urandom_range(7, 20));
      else len = 8'($urandom_range(0, 6));
      if (pick < 35) begin
        write_frame(start_addr, len, $urandom_range(0, 3) == 0,
                    int'($urandom_range(0, 2)), $urandom_range(0, 4) != 0);
      end else if (pick < 65) begin
        read_frame(start_addr, (len == 8'd255) ? 8'($urandom_range(0, 6)) : len,
                   int'($urandom_range(0, 2 * int'(len) + 3)), $urandom_range(0, 4) != 0);
      end else if (pick < 80) begin
        send_action($urandom_range(0, 1) ? ACT_LOCAL_WRITE : ACT_LOCAL_READ,
                    8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                                                 : $urandom_range(0, MAP_DEPTH - 1)));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_action(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_hold = 0;
    end else if (result_ch.valid && result_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no expected result pending");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %0h, actual %0h", want.out_byte, result_ch.out_byte);
          error_count++;
        end
        if (result_ch.tx_is_checksum !== want.tx_is_checksum) begin
          $error("tx_is_checksum: expected %0d, actual %0d", want.tx_is_checksum,
                 result_ch.tx_is_checksum);
          error_count++;
        end
        if (result_ch.stored !== want.stored) begin
          $error("stored: expected %0d, actual %0d", want.stored, result_ch.stored);
          error_count++;
        end
        if (result_ch.check_result !== want.check_result) begin
          $error("check_result: expected %0d, actual %0d", want.check_result,
                 result_ch.check_result);
          error_count++;
        end
      end
      sink_hold = idle_on ? int'($urandom_range(0, 16)) : 0;
      result_ch.ready <= (sink_hold == 0);
    end else if (sink_hold > 0) begin
      sink_hold--;
      result_ch.ready <= (sink_hold == 0);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.action <= ACT_WRITE_START;
    item_ch.bus_data <= 8'd0;
    item_ch.local_addr <= 8'd0;
    for (int i = 0; i < MAP_DEPTH; i++) shadow_map[i] = 8'd0;
    clear_shadow_frame();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_local_ports();
    test_write_frame();
    test_read_frame();
    test_stray_actions();
    test_random_traffic();

    wait_for_drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d transactions: %0d write frames, %0d read frames, %0d bytes stored.",
             items_sent, frames_written, frames_read, bytes_stored);
    $display("Checksums: %0d matched, %0d mismatched on receive, %0d sent on read.",
             checksum_matches, checksum_mismatches, checksums_sent);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
